// ----- rtl/gradient_vote_eye_center_core_macros.svh -----
// Assertion macros for the gradient vote eye center core checker.
// Depends on: nothing; expects clk and rst_n in the scope of use.
`ifndef GRADIENT_VOTE_EYE_CENTER_CORE_MACROS_SVH
`define GRADIENT_VOTE_EYE_CENTER_CORE_MACROS_SVH

// same-cycle implication
`define GVEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gvec assertion failed");

// next-cycle implication
`define GVEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gvec assertion failed");

`endif

// ----- rtl/gvec_pkg.sv -----
// Shared types and constants for the gradient vote eye center core.
// Depends on: nothing.
package gvec_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_VOTE   = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [3:0] REG_GRID_SIDE    = 4'd0;
    localparam logic [3:0] REG_WEIGHT_SHIFT = 4'd1;

    localparam logic [6:0] GRID_SIDE_RESET    = 7'd50;
    localparam logic [3:0] WEIGHT_SHIFT_RESET = 4'd0;

    localparam int SUM_W  = 40;
    localparam int GRAD_W = 16;
    // vote term stays below 2^27 for any 16-bit gradient
    localparam int QUOT_W = 28;
    localparam int FRAC_SHIFT = 12;

    typedef struct packed {
        logic weight_en;
        logic sum_en;
    } gvec_wr_t;

endpackage

// ----- rtl/gvec_store.sv -----
// Weight and vote sum memories, one write and one registered read port.
// Depends on: gvec_pkg.
module gvec_store import gvec_pkg::*;
#(
    parameter int Depth = 4096,
    parameter int AddrW = 12
)
(
    input  logic               clk,
    input  gvec_wr_t           wr_en,
    input  logic [AddrW-1:0]   wr_addr,
    input  logic [7:0]         wr_weight,
    input  logic [SUM_W-1:0]   wr_sum,
    input  logic [AddrW-1:0]   rd_addr,
    output logic [7:0]         rd_weight,
    output logic [SUM_W-1:0]   rd_sum
);

    logic [7:0]       weight_mem [Depth];
    logic [SUM_W-1:0] sum_mem [Depth];
    logic [7:0]       rd_weight_reg;
    logic [SUM_W-1:0] rd_sum_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.weight_en)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        if (wr_en.sum_en)
        begin
            sum_mem[wr_addr] <= wr_sum;
        end
        rd_weight_reg <= weight_mem[rd_addr];
        rd_sum_reg    <= sum_mem[rd_addr];
    end

    assign rd_weight = rd_weight_reg;
    assign rd_sum    = rd_sum_reg;

endmodule

// ----- rtl/gvec_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on: nothing beyond its parameters.
module gvec_div
#(
    parameter int XW  = 56,
    parameter int DVW = 28,
    parameter int QW  = 28
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [XW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [QW-1:0]  quotient
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DVW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]    lo_reg, lo_next;
    logic [DVW-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVW:0]     shifted;
    logic [DVW:0]     diff;

    always_comb
    begin
        shifted   = {rem_reg, lo_reg[QW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DVW'(dividend >> QW);
            lo_next   = dividend[QW-1:0];
            dvs_next  = divisor;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DVW])
            begin
                rem_next = diff[DVW-1:0];
                lo_next  = {lo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVW-1:0];
                lo_next  = {lo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

// ----- rtl/gradient_vote_eye_center_core.sv -----
// Top level of the gradient vote eye center core: sequencer and datapath.
// Depends on: gvec_pkg, gvec_store, gvec_div.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  command   | start, busy                | action, pos_x, pos_y, weight_value,
//            |                            | grad_x, grad_y
//  config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//  result    | result_valid (1-cycle)     | center_x, center_y, peak_sum
//
// Load writes one cell. Vote steps each cell through the multiplier states
// and, where the projection is positive, through the bit-serial divider.
// Report compares the cells in turn, one memory read per cell.
// Reset clears control state only; memories hold garbage until loaded.
// Results are a single-cycle strobe; the receiver cannot stall.
module gradient_vote_eye_center_core import gvec_pkg::*;
#(
    parameter int GRID_MAX = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               action,
    input  logic [5:0]               pos_x,
    input  logic [5:0]               pos_y,
    input  logic [7:0]               weight_value,
    input  logic signed [GRAD_W-1:0] grad_x,
    input  logic signed [GRAD_W-1:0] grad_y,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [3:0]               cfg_index,
    input  logic [7:0]               cfg_data,
    output logic                     result_valid,
    output logic [5:0]               center_x,
    output logic [5:0]               center_y,
    output logic [SUM_W-1:0]         peak_sum
);

    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_MAX);
    localparam int SW    = $clog2(GRID_MAX + 1);
    localparam int PW    = (CW > 6) ? CW : 6;
    localparam int DXW   = PW + 1;
    localparam int PRW   = DXW + GRAD_W;
    localparam int NW    = PRW + 1;
    localparam int SQW   = 2 * (NW - 1);
    localparam int XW    = SQW + 8;
    localparam int MW    = 2 * DXW;
    localparam int DVW   = MW + FRAC_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_V_RD,
        S_V_MUL1,
        S_V_MUL2,
        S_V_SQ,
        S_V_WMUL,
        S_V_DIVGO,
        S_V_DIV,
        S_V_WR,
        S_R_RD,
        S_R_CMP,
        S_R_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [5:0]              px_reg, px_next, py_reg, py_next;
    logic [7:0]              wv_reg, wv_next;
    logic signed [GRAD_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [CW-1:0]           cx_reg, cx_next, cy_reg, cy_next;
    logic signed [DXW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [PRW-1:0]   p1_reg, p1_next;
    logic signed [NW-1:0]    num_reg, num_next;
    logic [MW-1:0]           m2_reg, m2_next;
    logic [SQW-1:0]          sq_reg, sq_next;
    logic [XW-1:0]           x_reg, x_next;
    logic [SUM_W-1:0]        best_reg, best_next;
    logic [CW-1:0]           bx_reg, bx_next, by_reg, by_next;
    logic                    res_valid_reg, res_valid_next;
    logic [6:0]              grid_side_reg;
    logic [3:0]              weight_shift_reg;

    logic [SW-1:0]           side;
    logic [CW-1:0]           side_m1;
    logic                    last_cell;
    logic [AW-1:0]           cell_addr, load_addr, wr_addr;
    gvec_wr_t                wr_en;
    logic [SUM_W-1:0]        wr_sum;
    logic [7:0]              rd_weight;
    logic [SUM_W-1:0]        rd_sum;
    logic [7:0]              w_shifted;
    logic [SUM_W:0]          sum_add;
    logic                    div_start, div_done;
    logic [QUOT_W-1:0]       quot;
    logic [NW-2:0]           num_mag;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg    <= GRID_SIDE_RESET;
            weight_shift_reg <= WEIGHT_SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_GRID_SIDE)
            begin
                grid_side_reg <= cfg_data[6:0];
            end
            else if (cfg_index == REG_WEIGHT_SHIFT)
            begin
                weight_shift_reg <= cfg_data[3:0];
            end
        end
    end

    always_comb
    begin
        if (grid_side_reg == 7'd0)
        begin
            side = SW'(1);
        end
        else if (32'(grid_side_reg) > GRID_MAX)
        begin
            side = SW'(GRID_MAX);
        end
        else
        begin
            side = SW'(grid_side_reg);
        end
    end

    assign side_m1   = CW'(side - 1'b1);
    assign last_cell = (cx_reg == side_m1) && (cy_reg == side_m1);
    assign cell_addr = AW'(32'(cy_reg) * GRID_MAX + 32'(cx_reg));
    assign load_addr = AW'(32'(py_reg) * GRID_MAX + 32'(px_reg));
    assign wr_addr   = (state_reg == S_LOAD) ? load_addr : cell_addr;
    assign w_shifted = rd_weight >> weight_shift_reg;
    assign sum_add   = {1'b0, rd_sum} + (SUM_W + 1)'(quot);
    assign wr_sum    = (state_reg == S_LOAD) ? '0 :
                       (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]);
    assign num_mag   = num_reg[NW-2:0];
    assign div_start = (state_reg == S_V_DIVGO);

    always_comb
    begin
        wr_en.weight_en = 1'b0;
        wr_en.sum_en    = 1'b0;
        if (state_reg == S_LOAD)
        begin
            if (((PW + 1)'(px_reg) < (PW + 1)'(side)) &&
                ((PW + 1)'(py_reg) < (PW + 1)'(side)))
            begin
                wr_en.weight_en = 1'b1;
                wr_en.sum_en    = 1'b1;
            end
        end
        else if (state_reg == S_V_WR)
        begin
            wr_en.sum_en = 1'b1;
        end
    end

    gvec_store #(
        .Depth (DEPTH),
        .AddrW (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_weight (wv_reg),
        .wr_sum    (wr_sum),
        .rd_addr   (cell_addr),
        .rd_weight (rd_weight),
        .rd_sum    (rd_sum)
    );

    gvec_div #(
        .XW  (XW),
        .DVW (DVW),
        .QW  (QUOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  ({m2_reg, FRAC_SHIFT'(0)}),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        wv_next        = wv_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        p1_next        = p1_reg;
        num_next       = num_reg;
        m2_next        = m2_reg;
        sq_next        = sq_reg;
        x_next         = x_reg;
        best_next      = best_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        res_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next  = pos_x;
                    py_next  = pos_y;
                    wv_next  = weight_value;
                    gx_next  = grad_x;
                    gy_next  = grad_y;
                    cx_next  = '0;
                    cy_next  = '0;
                    case (action_t'(action))
                        ACT_LOAD:   state_next = S_LOAD;
                        ACT_VOTE:   state_next = S_V_RD;
                        ACT_REPORT: state_next = S_R_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_V_RD:
            begin
                dx_next    = $signed({1'b0, PW'(px_reg)}) - $signed({1'b0, PW'(cx_reg)});
                dy_next    = $signed({1'b0, PW'(py_reg)}) - $signed({1'b0, PW'(cy_reg)});
                state_next = S_V_MUL1;
            end
            S_V_MUL1:
            begin
                p1_next    = PRW'(dx_reg * gx_reg);
                m2_next    = MW'(dx_reg * dx_reg);
                state_next = S_V_MUL2;
            end
            S_V_MUL2:
            begin
                num_next   = NW'(p1_reg) + NW'(dy_reg * gy_reg);
                m2_next    = m2_reg + MW'(dy_reg * dy_reg);
                state_next = S_V_SQ;
            end
            S_V_SQ:
            begin
                sq_next = num_mag * num_mag;
                if ((dx_reg == '0 && dy_reg == '0) || num_reg[NW-1] || num_reg == '0)
                begin
                    if (last_cell)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_V_RD;
                        cx_next    = (cx_reg == side_m1) ? '0 : cx_reg + 1'b1;
                        cy_next    = (cx_reg == side_m1) ? cy_reg + 1'b1 : cy_reg;
                    end
                end
                else
                begin
                    state_next = S_V_WMUL;
                end
            end
            S_V_WMUL:
            begin
                x_next     = sq_reg * w_shifted;
                state_next = S_V_DIVGO;
            end
            S_V_DIVGO:
            begin
                state_next = S_V_DIV;
            end
            S_V_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_V_WR;
                end
            end
            S_V_WR:
            begin
                if (last_cell)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_V_RD;
                    cx_next    = (cx_reg == side_m1) ? '0 : cx_reg + 1'b1;
                    cy_next    = (cx_reg == side_m1) ? cy_reg + 1'b1 : cy_reg;
                end
            end
            S_R_RD:
            begin
                state_next = S_R_CMP;
            end
            S_R_CMP:
            begin
                if (cx_reg == '0 && cy_reg == '0)
                begin
                    best_next = rd_sum;
                    bx_next   = '0;
                    by_next   = '0;
                end
                else if (rd_sum > best_reg)
                begin
                    best_next = rd_sum;
                    bx_next   = cx_reg;
                    by_next   = cy_reg;
                end
                if (last_cell)
                begin
                    state_next = S_R_OUT;
                end
                else
                begin
                    state_next = S_R_RD;
                    cx_next    = (cx_reg == side_m1) ? '0 : cx_reg + 1'b1;
                    cy_next    = (cx_reg == side_m1) ? cy_reg + 1'b1 : cy_reg;
                end
            end
            S_R_OUT:
            begin
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        wv_reg   <= wv_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        p1_reg   <= p1_next;
        num_reg  <= num_next;
        m2_reg   <= m2_next;
        sq_reg   <= sq_next;
        x_reg    <= x_next;
        best_reg <= best_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign center_x     = 6'(bx_reg);
    assign center_y     = 6'(by_reg);
    assign peak_sum     = best_reg;

endmodule

// ----- rtl/gvec_checker.sv -----
// Port-level checker for the gradient vote eye center core, with its bind.
// Depends on: gvec_pkg, gradient_vote_eye_center_core_macros.svh.
`include "gradient_vote_eye_center_core_macros.svh"

module gvec_checker import gvec_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic       cfg_ready,
    input logic       result_valid
);

    `GVEC_ASSERT_NEXT(a_result_single, result_valid, !result_valid)
    `GVEC_ASSERT_NOW(a_result_after_work, result_valid, $past(busy))
    `GVEC_ASSERT_NEXT(a_busy_after_start, start && !busy && action != ACT_NONE, busy)
    `GVEC_ASSERT_NEXT(a_no_result_on_none, start && !busy && action == ACT_NONE, !busy)
    `GVEC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind gradient_vote_eye_center_core gvec_checker u_gvec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid)
);

// ----- sim/tb_gradient_vote_eye_center_core.sv -----
// Testbench for gradient_vote_eye_center_core: directed and random command traffic
// checked against an in-bench vote-grid predictor. Depends on gvec_pkg and the core RTL.
module tb_gradient_vote_eye_center_core import gvec_pkg::*;;

    localparam int GRID = 64;
    localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        action_t           act;
        logic [5:0]        x;
        logic [5:0]        y;
        logic [7:0]        w;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } grid_cmd_t;

    typedef struct {
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [39:0] peak;
    } center_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] action = '0;
    logic [5:0] pos_x = '0;
    logic [5:0] pos_y = '0;
    logic [7:0] weight_value = '0;
    logic signed [15:0] grad_x = '0;
    logic signed [15:0] grad_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic result_valid;
    logic [5:0] center_x;
    logic [5:0] center_y;
    logic [39:0] peak_sum;

    logic [7:0] weight_mem [GRID*GRID];
    longint unsigned sum_mem [GRID*GRID];
    logic [6:0] side_reg;
    logic [3:0] shift_reg;
    center_t pending_centers[$];
    int errors = 0;
    int gap_pct = 0;
    int stall_cycles = 0;

    gradient_vote_eye_center_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .weight_value(weight_value),
        .grad_x(grad_x), .grad_y(grad_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .center_x(center_x), .center_y(center_y), .peak_sum(peak_sum)
    );

    always #1 clk = ~clk;

    function automatic int active_side();
        if (side_reg == 0) return 1;
        if (side_reg > GRID) return GRID;
        return side_reg;
    endfunction

    function automatic void predict_command(grid_cmd_t c);
        int side;
        int idx;
        longint dx, dy, num, gxl, gyl;
        longint unsigned wt, term, m2;
        center_t res;
        side = active_side();
        case (c.act)
            ACT_LOAD:
                if (c.x < side && c.y < side)
                begin
                    idx = c.y * GRID + c.x;
                    weight_mem[idx] = c.w;
                    sum_mem[idx] = 0;
                end
            ACT_VOTE:
            begin
                gxl = c.gx;
                gyl = c.gy;
                for (int cy = 0; cy < side; cy++)
                    for (int cx = 0; cx < side; cx++)
                    begin
                        dx = longint'(c.x) - cx;
                        dy = longint'(c.y) - cy;
                        if (dx == 0 && dy == 0) continue;
                        num = dx * gxl + dy * gyl;
                        if (num <= 0) continue;
                        idx = cy * GRID + cx;
                        m2 = dx * dx + dy * dy;
                        wt = weight_mem[idx] >> shift_reg;
                        term = (longint'(num) * num * wt) / (m2 << 12);
                        if (term > SUM_SAT - sum_mem[idx]) sum_mem[idx] = SUM_SAT;
                        else sum_mem[idx] += term;
                    end
            end
            ACT_REPORT:
            begin
                res.cx = 0;
                res.cy = 0;
                res.peak = sum_mem[0];
                for (int cy = 0; cy < side; cy++)
                    for (int cx = 0; cx < side; cx++)
                        if (sum_mem[cy * GRID + cx] > res.peak)
                        begin
                            res.peak = sum_mem[cy * GRID + cx];
                            res.cx = cx;
                            res.cy = cy;
                        end
                pending_centers.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic send_command(grid_cmd_t c);
        @(negedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        start = 1'b1;
        action = c.act;
        pos_x = c.x;
        pos_y = c.y;
        weight_value = c.w;
        grad_x = c.gx;
        grad_y = c.gy;
        do @(posedge clk); while (busy);
        predict_command(c);
    endtask

    task automatic send_simple(action_t a, int x, int y, int w, int gx, int gy);
        grid_cmd_t c;
        c.act = a;
        c.x = x;
        c.y = y;
        c.w = w;
        c.gx = gx;
        c.gy = gy;
        send_command(c);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_centers.size() != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [7:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_GRID_SIDE) side_reg = data[6:0];
        else if (idx == REG_WEIGHT_SHIFT) shift_reg = data[3:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic fill_grid(int side);
        for (int y = 0; y < side; y++)
            for (int x = 0; x < side; x++)
                send_simple(ACT_LOAD, x, y, $urandom_range(255), 0, 0);
    endtask

    // whole-grid votes and reports on a 6 by 6 grid; leaves that corner of the store loaded
    task automatic test_full_grid();
        write_reg(REG_GRID_SIDE, 8'd6);
        fill_grid(6);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        send_simple(ACT_VOTE, 3, 2, 0, 16384, 0);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        send_simple(ACT_VOTE, 63, 63, 0, -32768, 32767);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
    endtask

    task automatic test_corner_cases();
        write_reg(REG_GRID_SIDE, 8'd0);
        send_simple(ACT_LOAD, 0, 0, 255, 0, 0);
        send_simple(ACT_VOTE, 0, 0, 0, 16384, 16384);
        send_simple(ACT_VOTE, 5, 0, 0, 16384, 0);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        write_reg(REG_GRID_SIDE, 8'd4);
        write_reg(REG_WEIGHT_SHIFT, 8'd8);
        send_simple(ACT_LOAD, 9, 1, 77, 0, 0);
        send_simple(ACT_LOAD, 2, 2, 0, 0, 0);
        send_simple(ACT_LOAD, 3, 3, 255, 0, 0);
        send_simple(ACT_VOTE, 63, 63, 0, 16384, 16384);
        send_simple(ACT_VOTE, 1, 1, 0, -16384, -16384);
        send_simple(ACT_VOTE, 2, 0, 0, 32767, -32768);
        send_simple(ACT_NONE, 1, 2, 3, 4, 5);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        write_reg(REG_WEIGHT_SHIFT, 8'd15);
        send_simple(ACT_VOTE, 0, 3, 0, 0, -16384);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        write_reg(REG_WEIGHT_SHIFT, 8'hF0);
        send_simple(ACT_VOTE, 3, 0, 0, -16384, 0);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(int count);
        grid_cmd_t c;
        int side;
        int roll;
        for (int n = 0; n < count; n++)
        begin
            if (n % 20 == 0)
            begin
                write_reg(REG_GRID_SIDE, ($urandom_range(3) == 0) ? 8'd2 : $urandom_range(6, 2));
                write_reg(REG_WEIGHT_SHIFT, $urandom_range(8));
            end
            side = active_side();
            roll = $urandom_range(99);
            c.w = $urandom_range(255);
            c.x = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(side + 1);
            c.y = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(side + 1);
            if ($urandom_range(4) == 0)
            begin
                c.gx = $urandom;
                c.gy = $urandom;
            end
            else
            begin
                c.gx = $signed($urandom_range(32768)) - 16384;
                c.gy = $signed($urandom_range(32768)) - 16384;
            end
            if (roll < 45) c.act = ACT_VOTE;
            else if (roll < 68) c.act = ACT_LOAD;
            else if (roll < 92) c.act = ACT_REPORT;
            else c.act = ACT_NONE;
            send_command(c);
        end
    endtask

    task automatic test_drain_pause();
        send_simple(ACT_VOTE, 1, 0, 0, 16384, 0);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
        @(negedge clk);
        start = 1'b0;
        while (pending_centers.size() != 0) @(negedge clk);
        send_simple(ACT_REPORT, 0, 0, 0, 0, 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_centers.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                center_t e;
                e = pending_centers.pop_front();
                if (center_x !== e.cx)
                begin
                    $error("center_x expected %0d actual %0d", e.cx, center_x);
                    errors++;
                end
                if (center_y !== e.cy)
                begin
                    $error("center_y expected %0d actual %0d", e.cy, center_y);
                    errors++;
                end
                if (peak_sum !== e.peak)
                begin
                    $error("peak_sum expected %0d actual %0d", e.peak, peak_sum);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < GRID * GRID; i++)
        begin
            weight_mem[i] = 0;
            sum_mem[i] = 0;
        end
        side_reg = GRID_SIDE_RESET;
        shift_reg = WEIGHT_SHIFT_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_full_grid();
        test_corner_cases();
        test_drain_pause();
        gap_pct = 18;
        test_random_traffic(27);
        gap_pct = 77;
        test_random_traffic(27);
        gap_pct = 0;
        test_random_traffic(26);
        wait_idle();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
